// ===== design/fefq_pkg.sv =====
// Shared constants and types for the filtered event fan-out queues.
// Used by every module of the block but fefq_ram; no dependencies of its own.
`timescale 1ns / 1ps

package fefq_pkg;

  localparam int unsigned QueueDepth      = 32;
  localparam int unsigned SubscriberCount = 5;
  localparam int unsigned EventWidth      = 32;

  localparam int unsigned AddrW   = $clog2(QueueDepth);
  localparam int unsigned CntW    = $clog2(QueueDepth + 1);
  localparam int unsigned SubIdxW = 3;

  // configuration port
  localparam int unsigned CfgIdxW   = 3;
  localparam int unsigned CfgDataW  = 32;
  localparam logic [CfgIdxW-1:0] CfgEnable  = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgFilter0 = 3'd1;

  // item kinds
  localparam logic KindPost = 1'b0;
  localparam logic KindRead = 1'b1;

  // stream payload widths, rounded up to whole bytes
  localparam int unsigned InDataW  = ((EventWidth + SubIdxW + 7) / 8) * 8;
  localparam int unsigned OutDataW = ((EventWidth + 2 * SubscriberCount + 7) / 8) * 8;

  typedef struct packed {
    logic                  kind;
    logic [SubIdxW-1:0]    sub;
    logic [EventWidth-1:0] word;
  } item_t;

  typedef struct packed {
    logic [SubscriberCount-1:0]            we;
    logic [SubscriberCount-1:0][AddrW-1:0] waddr;
    logic [EventWidth-1:0]                 wdata;
    logic [SubscriberCount-1:0]            re;
    logic [SubscriberCount-1:0][AddrW-1:0] raddr;
  } ram_req_t;

  typedef struct packed {
    logic [SubscriberCount-1:0] pop;
    logic [SubscriberCount-1:0] delivered;
    logic [SubscriberCount-1:0] pending;
  } rslt_t;

endpackage

// ===== design/fefq_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Stand-alone; no package dependency.
`timescale 1ns / 1ps

module fefq_ram #(
  parameter int unsigned Width = 32,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    // hold the last read data while no read is issued
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== design/fefq_cfg_regs.sv =====
// Configuration registers: subscriber enable bits and per-subscriber filters.
// Depends on fefq_pkg.
`timescale 1ns / 1ps

module fefq_cfg_regs (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  cfg_we_i,
  input  logic [fefq_pkg::CfgIdxW-1:0]                          cfg_idx_i,
  input  logic [fefq_pkg::CfgDataW-1:0]                         cfg_wdata_i,
  output logic [fefq_pkg::SubscriberCount-1:0]                  enable_o,
  output logic [fefq_pkg::SubscriberCount-1:0][fefq_pkg::EventWidth-1:0] filter_o
);

  logic [fefq_pkg::SubscriberCount-1:0]                          enable_q;
  logic [fefq_pkg::SubscriberCount-1:0][fefq_pkg::EventWidth-1:0] filter_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      enable_q <= '0;
      filter_q <= '1;
    end else if (cfg_we_i) begin
      if (cfg_idx_i == fefq_pkg::CfgEnable) begin
        enable_q <= cfg_wdata_i[fefq_pkg::SubscriberCount-1:0];
      end
      for (int s = 0; s < fefq_pkg::SubscriberCount; s++) begin
        if (cfg_idx_i == fefq_pkg::CfgIdxW'(int'(fefq_pkg::CfgFilter0) + s)) begin
          filter_q[s] <= cfg_wdata_i[fefq_pkg::EventWidth-1:0];
        end
      end
    end
  end

  assign enable_o = enable_q;
  assign filter_o = filter_q;

endmodule

// ===== design/fefq_queue_ctrl.sv =====
// Queue control: ring pointers and free counts per subscriber, filter match,
// and the write/read requests to the subscriber RAM banks. Depends on fefq_pkg.
`timescale 1ns / 1ps

module fefq_queue_ctrl (
  input  logic                                                  clk_i,
  input  logic                                                  rst_ni,
  input  logic                                                  accept_i,
  input  fefq_pkg::item_t                                       item_i,
  input  logic [fefq_pkg::SubscriberCount-1:0]                  enable_i,
  input  logic [fefq_pkg::SubscriberCount-1:0][fefq_pkg::EventWidth-1:0] filter_i,
  output fefq_pkg::ram_req_t                                    req_o,
  output fefq_pkg::rslt_t                                       rslt_o
);

  localparam int unsigned Sc = fefq_pkg::SubscriberCount;
  localparam logic [fefq_pkg::CntW-1:0]  CntFull = fefq_pkg::CntW'(fefq_pkg::QueueDepth);
  localparam logic [fefq_pkg::AddrW-1:0] PtrLast =
      fefq_pkg::AddrW'(fefq_pkg::QueueDepth - 1);

  logic [Sc-1:0][fefq_pkg::AddrW-1:0] wptr_q, wptr_d;
  logic [Sc-1:0][fefq_pkg::AddrW-1:0] rptr_q, rptr_d;
  logic [Sc-1:0][fefq_pkg::CntW-1:0]  free_q, free_d;
  logic [Sc-1:0]                      post, pop;

  always_comb begin
    wptr_d = wptr_q;
    rptr_d = rptr_q;
    free_d = free_q;
    for (int s = 0; s < Sc; s++) begin
      post[s] = accept_i && (item_i.kind == fefq_pkg::KindPost) && enable_i[s] &&
                (free_q[s] != '0) && (|(item_i.word & filter_i[s]));
      pop[s]  = accept_i && (item_i.kind == fefq_pkg::KindRead) &&
                (item_i.sub == fefq_pkg::SubIdxW'(s)) && enable_i[s] &&
                (free_q[s] != CntFull);
      if (post[s]) begin
        free_d[s] = free_q[s] - 1'b1;
        wptr_d[s] = (wptr_q[s] == PtrLast) ? '0 : wptr_q[s] + 1'b1;
      end
      if (pop[s]) begin
        free_d[s] = free_q[s] + 1'b1;
        rptr_d[s] = (rptr_q[s] == PtrLast) ? '0 : rptr_q[s] + 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q <= '0;
      rptr_q <= '0;
      for (int s = 0; s < Sc; s++) begin
        free_q[s] <= CntFull;
      end
    end else begin
      wptr_q <= wptr_d;
      rptr_q <= rptr_d;
      free_q <= free_d;
    end
  end

  always_comb begin
    req_o.we    = post;
    req_o.waddr = wptr_q;
    req_o.wdata = item_i.word;
    req_o.re    = pop;
    req_o.raddr = rptr_q;
    rslt_o.pop       = pop;
    rslt_o.delivered = post;
    for (int s = 0; s < Sc; s++) begin
      rslt_o.pending[s] = (free_d[s] != CntFull);
    end
  end

`ifndef SYNTH
  for (genvar g = 0; g < Sc; g++) begin : g_chk
    a_free_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
      free_q[g] <= CntFull)
      else $error("free count above queue depth");

    a_pop_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
      pop[g] |=> (free_q[g] == $past(free_q[g]) + 1'b1))
      else $error("pop did not free a slot");
  end

  a_post_read_excl: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !((|post) && (|pop)))
    else $error("post and pop in the same cycle");

  a_single_pop: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $onehot0(pop))
    else $error("more than one queue popped");
`endif

endmodule

// ===== design/filtered_event_fanout_queues_top.sv =====
// Top level of the filtered event fan-out queues: stream ports, output stage
// and one RAM bank per subscriber. Depends on fefq_pkg and all fefq modules.
`timescale 1ns / 1ps

// Usage
//   Input stream s_axis: tuser is the kind (0 post, 1 read); tdata carries the
//   event word and the subscriber index. A post offers the word to every open
//   subscriber whose filter matches and whose 32-entry ring has room; a read
//   pops the oldest word of one subscriber, or reports none.
//   Output stream m_axis: exactly one result per accepted item; tuser is
//   has_event, tdata holds the popped word, the delivered mask and the mask of
//   nonempty queues after the item.
//   Configuration: cfg_we_i writes register cfg_idx_i (0 enable bits,
//   1..5 filters); write only while the block is idle.
// Timing
//   The result becomes valid in the cycle after input accept; the popped word
//   comes out of the registered read port of the subscriber's RAM bank.
//   Throughput is one item per cycle unless m_axis stalls, set by pointer
//   update and RAM access both happening in the accept cycle.
// Reset and stall
//   Reset empties all queues (pointers and free counts), closes all slots and
//   sets every filter to all ones; RAM contents are left as they are.
//   While a result waits on m_axis_tready, s_axis_tready stays low, and the
//   waiting result and RAM read data hold.

module filtered_event_fanout_queues_top (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  // configuration
  input  logic                              cfg_we_i,
  input  logic [fefq_pkg::CfgIdxW-1:0]      cfg_idx_i,
  input  logic [fefq_pkg::CfgDataW-1:0]     cfg_wdata_i,
  // input items
  input  logic                              s_axis_tvalid,
  output logic                              s_axis_tready,
  // [31:0] event_word, [34:32] subscriber, rest zero
  input  logic [fefq_pkg::InDataW-1:0]      s_axis_tdata,
  // [0] kind
  input  logic                              s_axis_tuser,
  // result items
  output logic                              m_axis_tvalid,
  input  logic                              m_axis_tready,
  // [31:0] read_word, [36:32] delivered_mask, [41:37] pending_mask, rest zero
  output logic [fefq_pkg::OutDataW-1:0]     m_axis_tdata,
  // [0] has_event
  output logic                              m_axis_tuser
);

  localparam int unsigned Sc = fefq_pkg::SubscriberCount;
  localparam int unsigned Ew = fefq_pkg::EventWidth;

  logic                                enable;
  logic [Sc-1:0]                       enable_v;
  logic [Sc-1:0][Ew-1:0]               filter;
  logic                                accept;
  fefq_pkg::item_t                     item;
  fefq_pkg::ram_req_t                  req;
  fefq_pkg::rslt_t                     rslt, rslt_q;
  logic                                out_vld_q, out_vld_d;
  logic [Sc-1:0][Ew-1:0]               rdata;
  logic [Ew-1:0]                       read_word;

  assign enable = 1'b1;

  fefq_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .enable_o    (enable_v),
    .filter_o    (filter)
  );

  // take a new item whenever the output stage is empty or being drained
  assign s_axis_tready = !out_vld_q || m_axis_tready;
  assign accept        = s_axis_tvalid && s_axis_tready && enable;

  assign item.kind = s_axis_tuser;
  assign item.word = s_axis_tdata[Ew-1:0];
  assign item.sub  = s_axis_tdata[Ew +: fefq_pkg::SubIdxW];

  fefq_queue_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .accept_i (accept),
    .item_i   (item),
    .enable_i (enable_v),
    .filter_i (filter),
    .req_o    (req),
    .rslt_o   (rslt)
  );

  for (genvar g = 0; g < Sc; g++) begin : g_bank
    fefq_ram #(
      .Width (Ew),
      .Depth (fefq_pkg::QueueDepth)
    ) u_ram (
      .clk_i   (clk_i),
      .we_i    (req.we[g]),
      .waddr_i (req.waddr[g]),
      .wdata_i (req.wdata),
      .re_i    (req.re[g]),
      .raddr_i (req.raddr[g]),
      .rdata_o (rdata[g])
    );
  end

  always_comb begin
    if (accept) begin
      out_vld_d = 1'b1;
    end else if (m_axis_tready) begin
      out_vld_d = 1'b0;
    end else begin
      out_vld_d = out_vld_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else begin
      out_vld_q <= out_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      rslt_q <= rslt;
    end
  end

  // select the popped bank, zero when nothing was popped
  always_comb begin
    read_word = '0;
    for (int s = 0; s < Sc; s++) begin
      if (rslt_q.pop[s]) begin
        read_word = rdata[s];
      end
    end
  end

  assign m_axis_tvalid = out_vld_q;
  assign m_axis_tuser  = |rslt_q.pop;
  assign m_axis_tdata  = fefq_pkg::OutDataW'({rslt_q.pending, rslt_q.delivered, read_word});

endmodule

// ===== tb/sv/fefq_checker.sv =====
// Checker for the filtered event fan-out queues: watches the configuration port
// and both streams, keeps its own copy of the rings and compares every result.
// Depends on fefq_pkg.
`timescale 1ns / 1ps

module fefq_checker
  import fefq_pkg::*;
(
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 cfg_we_i,
  input  logic [CfgIdxW-1:0]   cfg_idx_i,
  input  logic [CfgDataW-1:0]  cfg_wdata_i,
  input  logic                 s_tvalid_i,
  input  logic                 s_tready_i,
  input  logic [InDataW-1:0]   s_tdata_i,
  input  logic                 s_tuser_i,
  input  logic                 m_tvalid_i,
  input  logic                 m_tready_i,
  input  logic [OutDataW-1:0]  m_tdata_i,
  input  logic                 m_tuser_i,
  output int                   fail_count_o,
  output int                   outstanding_o,
  output int                   posts_o,
  output int                   reads_o,
  output int                   pops_o,
  output int                   refused_o
);

  typedef struct packed {
    logic                       has_event;
    logic [EventWidth-1:0]      word;
    logic [SubscriberCount-1:0] delivered;
    logic [SubscriberCount-1:0] pending;
  } queue_result_t;

  logic [EventWidth-1:0]      ring [SubscriberCount][QueueDepth];
  logic [AddrW-1:0]           wr_ptr [SubscriberCount];
  logic [AddrW-1:0]           rd_ptr [SubscriberCount];
  logic [CntW-1:0]            room [SubscriberCount];
  logic [SubscriberCount-1:0] open_mask;
  logic [EventWidth-1:0]      filt [SubscriberCount];
  queue_result_t              awaited_results [$];

  int fails, posts, reads, pops, refused;

  assign fail_count_o = fails;
  assign posts_o      = posts;
  assign reads_o      = reads;
  assign pops_o       = pops;
  assign refused_o    = refused;

  // fan one post out to the rings, or pop one ring for a read
  task automatic fan_out_step(input logic kind, input logic [EventWidth-1:0] word,
                              input logic [SubIdxW-1:0] sub, output queue_result_t r);
    int s;
    r = '0;
    if (kind == KindPost) begin
      posts++;
      for (s = 0; s < SubscriberCount; s++) begin
        if (open_mask[s] && (word & filt[s]) != '0) begin
          if (room[s] != 0) begin
            ring[s][wr_ptr[s]] = word;
            wr_ptr[s]          = wr_ptr[s] + 1'b1;
            room[s]            = room[s] - 1'b1;
            r.delivered[s]     = 1'b1;
          end else begin
            refused++;
          end
        end
      end
    end else begin
      reads++;
      if (sub < SubscriberCount && open_mask[sub] && room[sub] != QueueDepth) begin
        r.has_event = 1'b1;
        r.word      = ring[sub][rd_ptr[sub]];
        rd_ptr[sub] = rd_ptr[sub] + 1'b1;
        room[sub]   = room[sub] + 1'b1;
        pops++;
      end
    end
    for (s = 0; s < SubscriberCount; s++) r.pending[s] = (room[s] != QueueDepth);
  endtask

  task automatic report_field(input string field, input logic [EventWidth-1:0] want,
                              input logic [EventWidth-1:0] got);
    if (want !== got) begin
      fails++;
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, want, got);
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    queue_result_t want, got;
    int s;
    if (!rst_ni) begin
      for (s = 0; s < SubscriberCount; s++) begin
        wr_ptr[s] = '0;
        rd_ptr[s] = '0;
        room[s]   = CntW'(QueueDepth);
        filt[s]   = '1;
      end
      open_mask = '0;
      awaited_results.delete();
      fails = 0; posts = 0; reads = 0; pops = 0; refused = 0;
      outstanding_o <= 0;
    end else begin
      // match the departing item first: it belongs to an earlier input
      if (m_tvalid_i && m_tready_i) begin
        got.has_event = m_tuser_i;
        got.word      = m_tdata_i[EventWidth-1:0];
        got.delivered = m_tdata_i[EventWidth +: SubscriberCount];
        got.pending   = m_tdata_i[EventWidth + SubscriberCount +: SubscriberCount];
        if (awaited_results.size() == 0) begin
          fails++;
          $display("%0t: result 0x%0h arrived with none expected", $time, m_tdata_i);
        end else begin
          want = awaited_results.pop_front();
          report_field("has_event", EventWidth'(want.has_event),
                       EventWidth'(got.has_event));
          report_field("read_word", want.word, got.word);
          report_field("delivered_mask", EventWidth'(want.delivered),
                       EventWidth'(got.delivered));
          report_field("pending_mask", EventWidth'(want.pending),
                       EventWidth'(got.pending));
        end
      end
      if (cfg_we_i) begin
        if (cfg_idx_i == CfgEnable)
          open_mask = cfg_wdata_i[SubscriberCount-1:0];
        else if (cfg_idx_i >= CfgFilter0 && cfg_idx_i < CfgFilter0 + SubscriberCount)
          filt[cfg_idx_i - CfgFilter0] = cfg_wdata_i[EventWidth-1:0];
      end
      if (s_tvalid_i && s_tready_i) begin
        fan_out_step(s_tuser_i, s_tdata_i[EventWidth-1:0],
                     s_tdata_i[EventWidth +: SubIdxW], want);
        awaited_results.push_back(want);
      end
      outstanding_o <= awaited_results.size();
    end
  end

endmodule

// ===== tb/sv/testbench.sv =====
// Top of the fan-out queue testbench: clock, reset, configuration phases and
// randomised post/read traffic. Depends on fefq_pkg, fefq_checker and the block.
`timescale 1ns / 1ps

module testbench;
  import fefq_pkg::*;

  localparam int Phases        = 8;
  localparam int PhaseItems    = 100;
  localparam int HoldAfter     = 400;
  localparam int HoldCycles    = 300;
  localparam int WatchdogLimit = 4000;
  localparam logic [CfgIdxW-1:0] CfgFirstUnused = CfgIdxW'(CfgFilter0 + SubscriberCount);

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we = 1'b0;
  logic [CfgIdxW-1:0]  cfg_idx = '0;
  logic [CfgDataW-1:0] cfg_wdata = '0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [InDataW-1:0]  s_tdata = '0;
  logic                s_tuser = 1'b0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OutDataW-1:0] m_tdata;
  logic                m_tuser;

  int fail_count, outstanding, posts, reads, pops, refused;
  int idle_cycles = 0;
  int n_settings = 0;
  bit tx_idle = 1'b1;
  bit rx_idle = 1'b1;

  logic [SubscriberCount-1:0] cfg_enable;
  logic [EventWidth-1:0]      cfg_filter [SubscriberCount];

  filtered_event_fanout_queues_top u_dut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_axis_tvalid (s_tvalid),
    .s_axis_tready (s_tready),
    .s_axis_tdata  (s_tdata),
    .s_axis_tuser  (s_tuser),
    .m_axis_tvalid (m_tvalid),
    .m_axis_tready (m_tready),
    .m_axis_tdata  (m_tdata),
    .m_axis_tuser  (m_tuser)
  );

  fefq_checker u_checker (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_we_i      (cfg_we),
    .cfg_idx_i     (cfg_idx),
    .cfg_wdata_i   (cfg_wdata),
    .s_tvalid_i    (s_tvalid),
    .s_tready_i    (s_tready),
    .s_tdata_i     (s_tdata),
    .s_tuser_i     (s_tuser),
    .m_tvalid_i    (m_tvalid),
    .m_tready_i    (m_tready),
    .m_tdata_i     (m_tdata),
    .m_tuser_i     (m_tuser),
    .fail_count_o  (fail_count),
    .outstanding_o (outstanding),
    .posts_o       (posts),
    .reads_o       (reads),
    .pops_o        (pops),
    .refused_o     (refused)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  // watchdog: fail and end the test once nothing moves for too long
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we)
        idle_cycles <= 0;
      else
        idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WatchdogLimit) begin
        $display("%0t: no item moved for %0d cycles", $time, idle_cycles);
        $display("filtered_event_fanout_queues_top test failed");
        $finish;
      end
    end
  end

  // receiver: random back-pressure, one long hold-off to fill the block
  initial begin
    int rx_count, wait_cycles;
    rx_count = 0;
    @(posedge rst_ni);
    @(posedge clk_i);
    forever begin
      wait_cycles = rx_idle ? $urandom_range(0, 15) : 0;
      if (rx_count == HoldAfter) wait_cycles = HoldCycles;
      if (wait_cycles > 0) begin
        m_tready <= 1'b0;
        repeat (wait_cycles) @(posedge clk_i);
      end
      m_tready <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid);
      rx_count++;
    end
  end

  function automatic logic [EventWidth-1:0] draw_word();
    case ($urandom_range(0, 3))
      0:       return $urandom();
      1:       return 32'h1 << $urandom_range(0, 31);
      2:       return $urandom() & $urandom() & $urandom();
      default: return ($urandom_range(0, 1) != 0) ? '1 : '0;
    endcase
  endfunction

  task automatic push_item(input logic kind, input logic [EventWidth-1:0] word,
                           input logic [SubIdxW-1:0] sub);
    int gap;
    gap = tx_idle ? $urandom_range(0, 15) : 0;
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= InDataW'({sub, word});
    do @(posedge clk_i); while (!s_tready);
  endtask

  task automatic push_random(input int post_pct);
    logic [SubIdxW-1:0] sub;
    // mostly valid indices, now and then an index past the last queue
    sub = ($urandom_range(0, 9) == 0) ? SubIdxW'($urandom_range(SubscriberCount, 7))
                                      : SubIdxW'($urandom_range(0, SubscriberCount - 1));
    if ($urandom_range(1, 100) <= post_pct)
      push_item(KindPost, draw_word(), SubIdxW'($urandom_range(0, 7)));
    else
      push_item(KindRead, $urandom(), sub);
  endtask

  // drain every result, then write all registers from cfg_enable/cfg_filter, and poke unused indices if asked
  task automatic settle_and_configure(input bit poke_unused);
    int i;
    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (2) @(posedge clk_i);
    for (i = 0; i <= SubscriberCount; i++) begin
      cfg_we    <= 1'b1;
      cfg_idx   <= (i == 0) ? CfgEnable : CfgIdxW'(CfgFilter0 + i - 1);
      cfg_wdata <= (i == 0) ? CfgDataW'(cfg_enable) : CfgDataW'(cfg_filter[i-1]);
      @(posedge clk_i);
    end
    if (poke_unused) begin
      for (i = CfgFirstUnused; i < (1 << CfgIdxW); i++) begin
        cfg_we    <= 1'b1;
        cfg_idx   <= CfgIdxW'(i);
        cfg_wdata <= $urandom();
        @(posedge clk_i);
      end
    end
    cfg_we <= 1'b0;
    n_settings++;
  endtask

  initial begin
    int ph, i, post_pct;
    rst_ni = 1'b0;
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // reset settings: every slot closed
    push_item(KindPost, '1, 3'd0);
    push_item(KindRead, '1, 3'd0);

    cfg_enable    = '1;
    cfg_filter[0] = '1;
    cfg_filter[1] = 32'h0000_0001;
    cfg_filter[2] = 32'h8000_0000;
    cfg_filter[3] = '0;
    cfg_filter[4] = 32'h0000_FFFF;
    settle_and_configure(1'b1);
    push_item(KindPost, '0, 3'd7);
    push_item(KindPost, 32'h0000_0001, 3'd0);
    push_item(KindPost, 32'h8000_0000, 3'd0);
    push_item(KindPost, '1, 3'd0);
    for (i = 0; i < 8; i++) push_item(KindRead, '0, SubIdxW'(i));

    // close slot zero while it still holds events
    cfg_enable = 5'b11110;
    settle_and_configure(1'b0);
    push_item(KindRead, 32'hA5A5_5A5A, 3'd0);
    push_item(KindPost, '1, 3'd0);

    for (ph = 0; ph < Phases; ph++) begin
      case (ph)
        0: begin
          cfg_enable = '1;
          for (i = 0; i < SubscriberCount; i++) cfg_filter[i] = '1;
          post_pct = 90;
        end
        2: begin
          cfg_enable = '0;
          for (i = 0; i < SubscriberCount; i++) cfg_filter[i] = '0;
          post_pct = 50;
        end
        default: begin
          cfg_enable = (ph == 1) ? '1 : SubscriberCount'($urandom());
          for (i = 0; i < SubscriberCount; i++) cfg_filter[i] = draw_word();
          case ($urandom_range(0, 2))
            0:       post_pct = 20;
            1:       post_pct = 50;
            default: post_pct = 85;
          endcase
        end
      endcase
      settle_and_configure(1'b0);
      tx_idle = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      rx_idle = (ph == 1) ? 1'b0 : ($urandom_range(0, 3) != 0);
      repeat (PhaseItems) push_random(post_pct);
    end

    s_tvalid <= 1'b0;
    do @(posedge clk_i); while (outstanding != 0);
    repeat (4) @(posedge clk_i);

    $display("Covered %0d posts (%0d copies refused by full rings) and %0d reads", posts,
             refused, reads);
    $display("with %0d events popped, over %0d register settings", pops, n_settings);
    if (fail_count == 0)
      $display("filtered_event_fanout_queues_top test passed");
    else
      $display("filtered_event_fanout_queues_top test failed");
    $finish;
  end

endmodule
